// ----- rtl/rmsd_pkg.sv -----
// Shared types and codes for the rolling-mean spike detector.
// Holds the input and output word structs, register indexes and trigger codes.
// No dependencies.
package rmsd_pkg;

  typedef struct packed {
    logic [15:0] sample;
    logic        sample_valid;
    logic [31:0] frame_index;
    logic [47:0] time_stamp;
  } in_t;

  typedef struct packed {
    logic [31:0] spike_frame;
    logic [47:0] spike_time;
    logic [15:0] spike_value;
    logic [15:0] rolling_mean;
    logic [15:0] mean_distance;
    logic [6:0]  window_count;
    logic [1:0]  trigger_kind;
    logic [31:0] spike_total;
  } out_t;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ABS_THRESHOLD   = 2'd0,
    REG_LOCAL_THRESHOLD = 2'd1,
    REG_HOLDOFF_FRAMES  = 2'd2
  } reg_idx_t;

  localparam logic [1:0] KIND_ABS   = 2'd0;
  localparam logic [1:0] KIND_LOCAL = 2'd1;
  localparam logic [1:0] KIND_BOTH  = 2'd2;

endpackage

// ----- rtl/rmsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Holds the sample window of the spike detector. No dependencies.
module rmsd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/rolling_mean_spike_detector.sv -----
// Rolling-mean spike detector top level: window RAM, running sum, restoring divider.
// Depends on rmsd_pkg and rmsd_ram.
//
// Usage:
//   Input channel (in_valid / in_stall / in_word) takes one frame word. A word
//   with sample_valid low is taken and changes nothing. A valid
//   word goes through the window update, then a restoring divider that
//   produces one quotient bit per cycle (SUMW = 16 + clog2(WINDOW+1) bits,
//   23 at WINDOW = 100) to form the mean, then the threshold checks.
//   The record is raised from the output register after the check step, which
//   waits while the register is full. A valid word that passes the holdoff
//   and fill gates holds in_stall high through the update, divide and check
//   steps, so no new word is taken until then; a gated word frees the block
//   after the update step. in_stall is high while a word is being worked on.
//   Output channel (out_valid / out_stall / out_word) carries at most one spike
//   record per word from an output register. The next word is accepted while a
//   record waits; a finished check waits only if the register is still full.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   thresholds and holdoff length; cfg_ready is always high.
//   Synchronous reset clears counters, the running sum, holdoff and registers.
//   The window RAM is not cleared: an entry is used only after it was written.
module rolling_mean_spike_detector #(
  parameter int unsigned WINDOW   = 100,
  parameter int unsigned MIN_FILL = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rmsd_pkg::in_t                  in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rmsd_pkg::out_t                 out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rmsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  import rmsd_pkg::*;

  localparam int unsigned AW   = $clog2(WINDOW);
  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned SUMW = 16 + CW;
  localparam int unsigned DCW  = $clog2(SUMW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state;

  logic [15:0]     abs_thr;
  logic [15:0]     loc_thr;
  logic [15:0]     holdoff_frames;
  logic [15:0]     holdoff_left;
  logic [31:0]     spike_count;
  logic [AW-1:0]   wpos;
  logic [CW-1:0]   held;
  logic [SUMW-1:0] run_sum;
  logic [15:0]     smp;
  logic [31:0]     frame;
  logic [47:0]     tstamp;
  logic [CW-1:0]   rem;
  logic [SUMW-1:0] quo;
  logic [DCW-1:0]  div_cnt;

  logic            accept;
  logic            full;
  logic [CW-1:0]   held_next;
  logic [SUMW-1:0] sum_next;
  logic [AW-1:0]   wpos_next;
  logic [15:0]     rd_data;
  logic [CW:0]     shifted;
  logic [CW+1:0]   trial;
  logic            ge;
  logic [15:0]     mean;
  logic [15:0]     distance;
  logic            abs_trig;
  logic            loc_trig;
  logic [1:0]      kind;
  logic            out_free;
  logic            fire;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  rmsd_ram #(
    .WIDTH(16),
    .DEPTH(WINDOW)
  ) u_window (
    .clk     (clk),
    .wr_en   (state == ST_UPD),
    .wr_addr (wpos),
    .wr_data (smp),
    .rd_en   (accept),
    .rd_addr (wpos),
    .rd_data (rd_data)
  );

  always_comb begin
    full      = (held == CW'(WINDOW));
    held_next = full ? held : held + CW'(1);
    sum_next  = run_sum - (full ? SUMW'(rd_data) : '0) + SUMW'(smp);
    wpos_next = (wpos == AW'(WINDOW - 1)) ? '0 : wpos + AW'(1);

    // restoring divider step: shift in one dividend bit, subtract if it fits
    shifted = {rem, quo[SUMW-1]};
    trial   = {1'b0, shifted} - {2'b00, held};
    ge      = !trial[CW+1];

    mean     = quo[15:0];
    distance = (smp >= mean) ? smp - mean : mean - smp;
    abs_trig = smp > abs_thr;
    loc_trig = full && (distance > loc_thr);
    if (abs_trig && loc_trig) begin
      kind = KIND_BOTH;
    end else if (abs_trig) begin
      kind = KIND_ABS;
    end else begin
      kind = KIND_LOCAL;
    end
    out_free = !out_valid || !out_stall;
    fire     = (state == ST_FIN) && out_free && (abs_trig || loc_trig);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      abs_thr      <= '0;
      loc_thr      <= '0;
      holdoff_frames <= '0;
      holdoff_left <= '0;
      spike_count  <= '0;
      wpos         <= '0;
      held         <= '0;
      run_sum      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ABS_THRESHOLD:   abs_thr        <= cfg_data;
          REG_LOCAL_THRESHOLD: loc_thr        <= cfg_data;
          REG_HOLDOFF_FRAMES:  holdoff_frames <= cfg_data;
          default: ;
        endcase
      end

      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept && in_word.sample_valid) begin
            smp    <= in_word.sample;
            frame  <= in_word.frame_index;
            tstamp <= in_word.time_stamp;
            if (holdoff_left != '0) begin
              holdoff_left <= holdoff_left - 16'd1;
            end
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          held    <= held_next;
          run_sum <= sum_next;
          wpos    <= wpos_next;
          rem     <= '0;
          quo     <= sum_next;
          div_cnt <= DCW'(SUMW - 1);
          if ((holdoff_left != '0) || (11'(held_next) < 11'(MIN_FILL))) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= ge ? trial[CW-1:0] : shifted[CW-1:0];
          quo <= {quo[SUMW-2:0], ge};
          if (div_cnt == '0) begin
            state <= ST_FIN;
          end else begin
            div_cnt <= div_cnt - DCW'(1);
          end
        end
        ST_FIN: begin
          // hold until the output register can take a record
          if (out_free) begin
            if (fire) begin
              spike_count  <= spike_count + 32'd1;
              holdoff_left <= holdoff_frames;
              out_word.spike_frame   <= frame;
              out_word.spike_time    <= tstamp;
              out_word.spike_value   <= smp;
              out_word.rolling_mean  <= mean;
              out_word.mean_distance <= distance;
              out_word.window_count  <= 7'(held);
              out_word.trigger_kind  <= kind;
              out_word.spike_total   <= spike_count + 32'd1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(WINDOW))
    else $error("window fill count above window size");

  a_wpos_bound: assert property (@(posedge clk) disable iff (rst)
    wpos <= AW'(WINDOW - 1))
    else $error("write position outside window");

  a_valid_word_updates: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.sample_valid |=> state == ST_UPD)
    else $error("valid word did not start window update");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> held != '0)
    else $error("divide by zero count");

  a_record_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("record raised outside the check step");

endmodule

// ----- tb/rolling_mean_spike_detector_test.sv -----
// Self-checking bench for rolling_mean_spike_detector: directed frame table, then
// randomized phases with threshold changes, random input gaps and output stalls.
// Depends on rmsd_pkg and the block's RTL; spike records are predicted in-line.
module rolling_mean_spike_detector_test;
  import rmsd_pkg::*;

  localparam int unsigned WINDOW      = 100;
  localparam int unsigned MIN_FILL    = 10;
  localparam int unsigned SETTLE      = 40;      // above the accept-to-record latency
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_WORDS = 105;
  localparam int unsigned MAX_PRINTS  = 100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Ten full-scale samples: mean equals the sample, absolute trigger only.
  localparam out_t FIRST_SPIKE = '{
    spike_frame:   32'hFFFF_FFFF,
    spike_time:    48'hFFFF_FFFF_FFFF,
    spike_value:   16'hFFFF,
    rolling_mean:  16'hFFFF,
    mean_distance: 16'h0000,
    window_count:  7'd10,
    trigger_kind:  KIND_ABS,
    spike_total:   32'd1
  };

  typedef enum logic [1:0] {EXPECT_MODEL, EXPECT_QUIET, EXPECT_RECORD} row_check_t;

  typedef struct {
    in_t        word;
    row_check_t how;
    out_t       rec;
  } dir_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  // Detector state as the bench sees it
  logic [15:0] win_mem [WINDOW];
  int unsigned wr_pos      = 0;
  int unsigned held_cnt    = 0;
  logic [22:0] win_sum     = '0;
  logic [15:0] holdoff_cnt = '0;
  logic [31:0] spike_cnt   = '0;
  logic [15:0] thr_abs     = '0;
  logic [15:0] thr_local   = '0;
  logic [15:0] holdoff_len = '0;

  out_t        pending_spikes [$];
  dir_row_t    dir_rows [$];
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned flow_left   = 0;
  int unsigned stall_pick  = 0;

  rolling_mean_spike_detector #(
    .WINDOW   (WINDOW),
    .MIN_FILL (MIN_FILL)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d spikes outstanding", cycle_count,
               pending_spikes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("cycle %0d: %s", cycle_count, what);
  endtask

  // Advance the window by one frame word; return 1 with the record on a spike.
  function automatic bit detect_spike(input in_t w, output out_t rec);
    int unsigned mean_v;
    int unsigned dist_v;
    bit          abs_hit;
    bit          loc_hit;
    rec = '0;
    if (!w.sample_valid) return 0;
    if (holdoff_cnt != 0) holdoff_cnt--;
    // evict the oldest entry only once the ring is full
    if (held_cnt == WINDOW) win_sum -= win_mem[wr_pos];
    else held_cnt++;
    win_mem[wr_pos] = w.sample;
    win_sum += w.sample;
    wr_pos = (wr_pos == WINDOW - 1) ? 0 : wr_pos + 1;
    if (holdoff_cnt != 0 || held_cnt < MIN_FILL) return 0;
    mean_v  = win_sum / held_cnt;
    dist_v  = (w.sample >= mean_v) ? w.sample - mean_v : mean_v - w.sample;
    abs_hit = w.sample > thr_abs;
    loc_hit = (held_cnt == WINDOW) && (dist_v > thr_local);
    if (!abs_hit && !loc_hit) return 0;
    spike_cnt++;
    holdoff_cnt       = holdoff_len;
    rec.spike_frame   = w.frame_index;
    rec.spike_time    = w.time_stamp;
    rec.spike_value   = w.sample;
    rec.rolling_mean  = mean_v[15:0];
    rec.mean_distance = dist_v[15:0];
    rec.window_count  = held_cnt[6:0];
    rec.trigger_kind  = (abs_hit && loc_hit) ? KIND_BOTH : (abs_hit ? KIND_ABS : KIND_LOCAL);
    rec.spike_total   = spike_cnt;
    return 1;
  endfunction

  task automatic check_spike(input out_t want);
    if (out_word.spike_frame !== want.spike_frame)
      report_mismatch($sformatf("spike_frame %0h, want %0h",
                                out_word.spike_frame, want.spike_frame));
    if (out_word.spike_time !== want.spike_time)
      report_mismatch($sformatf("spike_time %0h, want %0h",
                                out_word.spike_time, want.spike_time));
    if (out_word.spike_value !== want.spike_value)
      report_mismatch($sformatf("spike_value %0h, want %0h",
                                out_word.spike_value, want.spike_value));
    if (out_word.rolling_mean !== want.rolling_mean)
      report_mismatch($sformatf("rolling_mean %0h, want %0h",
                                out_word.rolling_mean, want.rolling_mean));
    if (out_word.mean_distance !== want.mean_distance)
      report_mismatch($sformatf("mean_distance %0h, want %0h",
                                out_word.mean_distance, want.mean_distance));
    if (out_word.window_count !== want.window_count)
      report_mismatch($sformatf("window_count %0d, want %0d",
                                out_word.window_count, want.window_count));
    if (out_word.trigger_kind !== want.trigger_kind)
      report_mismatch($sformatf("trigger_kind %0d, want %0d",
                                out_word.trigger_kind, want.trigger_kind));
    if (out_word.spike_total !== want.spike_total)
      report_mismatch($sformatf("spike_total %0d, want %0d",
                                out_word.spike_total, want.spike_total));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_spikes.size() == 0) begin
        report_mismatch("spike record with none expected");
      end else begin
        check_spike(pending_spikes[0]);
        pending_spikes.delete(0);
      end
    end
  end

  // Output stalls: short flows and stalls, now and then a long one of either
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (flow_left != 0) begin
      flow_left--;
      out_stall <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 15) begin
        flow_left = $urandom_range(20, 150);
        out_stall <= 1'b0;
      end else if (stall_pick < 55) begin
        flow_left = $urandom_range(0, 4);
        out_stall <= 1'b0;
      end else if (stall_pick < 95) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(15, 60);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic int unsigned next_gap();
    int unsigned pick;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 94) return $urandom_range(0, 2);
    return $urandom_range(10, 80);
  endfunction

  // Hold the word until taken, log what it should produce, then drop valid for a random gap, if any.
  task automatic offer_word(input in_t w, input row_check_t how, input out_t typed_rec);
    out_t        rec;
    bit          fires;
    int unsigned gap;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    fires = detect_spike(w, rec);
    case (how)
      EXPECT_MODEL:  if (fires) pending_spikes.insert(pending_spikes.size(), rec);
      EXPECT_RECORD: pending_spikes.insert(pending_spikes.size(), typed_rec);
      default: ;
    endcase
    gap = next_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait out every outstanding record plus the pipeline tail.
  task automatic drain_spikes();
    in_valid <= 1'b0;
    while (pending_spikes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ABS_THRESHOLD:   thr_abs     = val;
      REG_LOCAL_THRESHOLD: thr_local   = val;
      REG_HOLDOFF_FRAMES:  holdoff_len = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] abs_thr, input logic [15:0] local_thr,
                           input logic [15:0] hold);
    write_reg(REG_ABS_THRESHOLD, abs_thr);
    write_reg(REG_LOCAL_THRESHOLD, local_thr);
    write_reg(REG_HOLDOFF_FRAMES, hold);
    write_reg(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(input logic [15:0] s, input logic v, input logic [31:0] f,
                                  input logic [47:0] t, input row_check_t how,
                                  input out_t rec);
    dir_row_t row;
    row.word = '{sample: s, sample_valid: v, frame_index: f, time_stamp: t};
    row.how  = how;
    row.rec  = rec;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic in_t random_word(input logic [15:0] base, input logic [15:0] spread);
    in_t         w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w.sample_valid = ($urandom_range(0, 9) != 0);
    if (pick < 80) w.sample = base + 16'($urandom_range(0, spread));
    else if (pick < 92) w.sample = 16'($urandom);
    else if (pick < 96) w.sample = 16'hFFFF;
    else w.sample = 16'h0000;
    w.frame_index = $urandom;
    w.time_stamp  = {16'($urandom), 32'($urandom)};
    return w;
  endfunction

  initial begin
    logic [15:0] base;
    logic [15:0] spread;
    in_t         w;
    int unsigned n;

    // Reset thresholds are zero: any nonzero sample fires once the fill gate opens.
    add_row(16'hFFFF, 1'b0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, EXPECT_QUIET, '0);
    for (int i = 1; i < MIN_FILL; i++)
      add_row(16'hFFFF, 1'b1, 32'(i), 48'(i * 1000), EXPECT_QUIET, '0);
    add_row(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, EXPECT_RECORD, FIRST_SPIKE);
    add_row(16'h0000, 1'b1, 32'h0000_0000, 48'h0, EXPECT_QUIET, '0);
    add_row(16'h0001, 1'b1, 32'hAAAA_AAAA, 48'h5555_5555_5555, EXPECT_MODEL, '0);
    add_row(16'h8000, 1'b1, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, EXPECT_MODEL, '0);
    add_row(16'h00FF, 1'b1, 32'h0000_0001, 48'h0000_0000_0001, EXPECT_MODEL, '0);
    add_row(16'hFF00, 1'b1, 32'h8000_0000, 48'h8000_0000_0000, EXPECT_MODEL, '0);
    add_row(16'h1234, 1'b0, 32'h1234_5678, 48'h1234_5678_9ABC, EXPECT_MODEL, '0);
    add_row(16'h7FFF, 1'b1, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, EXPECT_MODEL, '0);
    add_row(16'hAAAA, 1'b1, 32'hFFFF_0000, 48'hFFFF_0000_FFFF, EXPECT_MODEL, '0);
    add_row(16'h5555, 1'b1, 32'h0000_FFFF, 48'h0000_FFFF_0000, EXPECT_MODEL, '0);
    add_row(16'hFFFF, 1'b1, 32'hDEAD_0000, 48'h0123_4567_89AB, EXPECT_MODEL, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) offer_word(dir_rows[i].word, dir_rows[i].how, dir_rows[i].rec);

    for (int p = 0; p < PHASES; p++) begin
      drain_spikes();
      base   = 16'($urandom_range(0, 16'hF000));
      spread = 16'($urandom_range(16, 16'h0800));
      case (p)
        0: configure(16'hFFFF, 16'h0000, 16'h0000);        // local trigger only
        1: configure(16'h0000, 16'hFFFF, 16'd3);           // absolute trigger only
        PHASES - 1: configure(base + 16'($urandom_range(0, spread)),
                              16'($urandom_range(0, spread)), 16'hFFFF);
        default: configure(base + 16'($urandom_range(0, spread)),
                           16'($urandom_range(0, spread / 2)),
                           16'($urandom_range(0, 12)));
      endcase
      n = 0;
      while (n < PHASE_WORDS) begin
        w = random_word(base, spread);
        offer_word(w, EXPECT_MODEL, '0);
        if (w.sample_valid) n++;
      end
    end
    drain_spikes();

    if (errors == 0 && pending_spikes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
